// ----- src/pmbr_pkg.sv -----
// package for the park-miller bounded random block
// shared constants, controller command and datapath status types; no dependencies
`default_nettype none

package pmbr_pkg;

   localparam int SeedWidth  = 31;
   localparam int BoundWidth = 32;
   localparam int MultWidth  = 15;
   localparam int ProdWidth  = SeedWidth + MultWidth;

   localparam logic [MultWidth-1:0]  PmMult      = 15'd16807;
   localparam logic [SeedWidth-1:0]  PmModulus   = 31'h7FFF_FFFF;
   localparam logic [SeedWidth-1:0]  ZeroSeedSub = 31'd123459876;
   localparam logic [SeedWidth-1:0]  SeedReset   = 31'd1;
   localparam logic [BoundWidth-1:0] DefaultBound = 32'h0000_7FFF;
   localparam logic [BoundWidth-1:0] BoundAllOnes = 32'hFFFF_FFFF;

   localparam int DivSteps = SeedWidth;
   localparam int CntWidth = $clog2(DivSteps);

   localparam logic OpGenerate = 1'b0;
   localparam logic OpLoad     = 1'b1;

   typedef struct packed {
      logic load_seed;
      logic capture;
      logic mul;
      logic fold;
      logic div_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic bypass;
   } sts_type;

endpackage

`default_nettype wire

// ----- src/pmbr_dpath.sv -----
// datapath: seed register, multiply and fold step, serial remainder unit, result register
// depends on pmbr_pkg
`default_nettype none

module pmbr_dpath
   import pmbr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmd_type               cmd,
   output sts_type                    sts,
   input  wire logic                  csr_wr_en,
   input  wire logic                  csr_wr_data,
   input  wire logic [SeedWidth-1:0]  req_seed_value,
   input  wire logic [BoundWidth-1:0] req_bound,
   output logic      [SeedWidth-1:0]  rsp_value
);

   logic [SeedWidth-1:0]  seed_ff, seed_in;
   logic                  zbd_ff, zbd_in;
   logic [BoundWidth-1:0] div_ff, div_in;
   logic                  bypass_ff, bypass_in;
   logic [ProdWidth-1:0]  prod_ff, prod_in;
   logic [SeedWidth-1:0]  dvd_ff, dvd_in;
   logic [BoundWidth-1:0] rem_ff, rem_in;
   logic [SeedWidth-1:0]  value_ff, value_in;

   logic [BoundWidth-1:0] lim;
   logic [SeedWidth-1:0]  mul_src;
   logic [SeedWidth:0]    fold_sum;
   logic [SeedWidth-1:0]  fold_res;
   logic [BoundWidth:0]   trial;
   logic [BoundWidth:0]   trial_sub;

   always_comb begin
      lim = ((req_bound == '0) && zbd_ff) ? DefaultBound : req_bound;
      mul_src = (seed_ff == '0) ? ZeroSeedSub : seed_ff;
      fold_sum = {1'b0, prod_ff[SeedWidth-1:0]}
               + {{(SeedWidth + 1 - MultWidth){1'b0}}, prod_ff[ProdWidth-1:SeedWidth]};
      fold_res = (fold_sum >= {1'b0, PmModulus}) ? SeedWidth'(fold_sum - {1'b0, PmModulus})
                                                 : fold_sum[SeedWidth-1:0];
      trial = {rem_ff, dvd_ff[SeedWidth-1]};
      trial_sub = trial - {1'b0, div_ff};
   end

   always_comb begin
      zbd_in    = csr_wr_en ? csr_wr_data : zbd_ff;
      seed_in   = seed_ff;
      div_in    = div_ff;
      bypass_in = bypass_ff;
      prod_in   = prod_ff;
      dvd_in    = dvd_ff;
      rem_in    = rem_ff;
      value_in  = value_ff;
      if (cmd.load_seed) begin
         seed_in = req_seed_value;
      end
      if (cmd.capture) begin
         div_in    = lim + BoundWidth'(1);
         bypass_in = (lim == BoundAllOnes);
      end
      if (cmd.mul) begin
         prod_in = ProdWidth'(mul_src) * ProdWidth'(PmMult);
      end
      if (cmd.fold) begin
         seed_in = fold_res;
         dvd_in  = fold_res;
         rem_in  = '0;
      end
      if (cmd.div_step) begin
         dvd_in = {dvd_ff[SeedWidth-2:0], 1'b0};
         rem_in = (trial >= {1'b0, div_ff}) ? trial_sub[BoundWidth-1:0]
                                            : trial[BoundWidth-1:0];
      end
      if (cmd.out_load) begin
         value_in = bypass_ff ? seed_ff : rem_ff[SeedWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= SeedReset;
         zbd_ff  <= 1'b0;
      end else begin
         seed_ff <= seed_in;
         zbd_ff  <= zbd_in;
      end
   end

   always_ff @(posedge clock) begin
      div_ff    <= div_in;
      bypass_ff <= bypass_in;
      prod_ff   <= prod_in;
      dvd_ff    <= dvd_in;
      rem_ff    <= rem_in;
      value_ff  <= value_in;
   end

   assign sts.bypass = bypass_ff;
   assign rsp_value  = value_ff;

endmodule

`default_nettype wire

// ----- src/pmbr_ctrl.sv -----
// controller: sequences accept, multiply, fold, serial remainder and result hand-off
// depends on pmbr_pkg
`default_nettype none

module pmbr_ctrl
   import pmbr_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire logic    req_op,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output cmd_type      cmd,
   input  wire sts_type sts
);

   localparam logic [2:0] StIdle   = 3'd0;
   localparam logic [2:0] StMul    = 3'd1;
   localparam logic [2:0] StFold   = 3'd2;
   localparam logic [2:0] StDiv    = 3'd3;
   localparam logic [2:0] StFinish = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                accept;

   assign req_ready = (state_ff == StIdle);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         StIdle: begin
            if (accept) begin
               if (req_op == OpLoad) begin
                  cmd.load_seed = 1'b1;
               end else begin
                  cmd.capture = 1'b1;
                  state_in    = StMul;
               end
            end
         end
         StMul: begin
            cmd.mul  = 1'b1;
            state_in = StFold;
         end
         StFold: begin
            cmd.fold = 1'b1;
            cnt_in   = '0;
            state_in = sts.bypass ? StFinish : StDiv;
         end
         StDiv: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + CntWidth'(1);
            if (cnt_ff == CntWidth'(DivSteps - 1)) begin
               state_in = StFinish;
            end
         end
         StFinish: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/park_miller_bounded_random.sv -----
// top level of the park-miller bounded random generator
// depends on pmbr_pkg, pmbr_ctrl and pmbr_dpath
//
//   port group  direction  contents
//   req_        in         op, seed_value, bound (valid/ready)
//   rsp_        out        value (valid/ready)
//   csr_        in         zero_bound_default write (enable/data)
//
// a load item writes the seed on accept; a generate item runs from accept to
// result through one multiply, one modular fold, the bit-serial remainder unit
// and one result load (the remainder unit is skipped when the bound is all ones)
// reset sets the seed to one and clears the register and all handshakes
// a result waiting on rsp_ready does not block the next accept; a following
// generate item holds in its last step until the result slot is free
`default_nettype none

module park_miller_bounded_random
   import pmbr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_op,
   input  wire logic [SeedWidth-1:0]  req_seed_value,
   input  wire logic [BoundWidth-1:0] req_bound,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic      [SeedWidth-1:0]  rsp_value,
   input  wire logic                  csr_wr_en,
   input  wire logic                  csr_wr_data
);

   cmd_type cmd;
   sts_type sts;

   pmbr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_op),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   pmbr_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_seed_value (req_seed_value),
      .req_bound      (req_bound),
      .rsp_value      (rsp_value)
   );

endmodule

`default_nettype wire
